// ----- rtl/core/nnfs_pkg.sv -----
// Package for the nearest-neighbor frame scaler core.
// Types, codes and reset constants shared by all nnfs_* modules; no dependencies.
package nnfs_pkg;

    localparam int LINE_DEPTH_DEF = 512;
    localparam int MAX_COPIES_DEF = 4;
    localparam int RESULT_CAP     = 4;

    localparam int SRC_WIDTH_RST  = 256;
    localparam int SRC_HEIGHT_RST = 240;
    localparam int DST_WIDTH_RST  = 480;
    localparam int DST_HEIGHT_RST = 320;

    localparam int SRC_H_MAX = 512;
    localparam int DST_MAX   = 2048;

    localparam int NUM_W   = 21;
    localparam int PIX_W   = 16;
    localparam int POS_W   = 11;
    localparam int CFG_W   = 12;
    localparam int SRC_W   = 10;
    localparam int DST_W   = 12;
    localparam int TDATA_W = 56;
    localparam int TUSER_W = 4;

    typedef enum logic [1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        MODE_PIXEL  = 1'b0,
        MODE_REPLAY = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_REPLAY_IDLE = 2'd1,
        STAT_DROPPED     = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RUN,
        ST_COL_BOUND,
        ST_SRC_END,
        ST_ROW_ADV,
        ST_OWE_SCAN,
        ST_ROW_BOUND,
        ST_REP_END,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [SRC_W-1:0] sw;
        logic [SRC_W-1:0] sh;
        logic [DST_W-1:0] dw;
        logic [DST_W-1:0] dh;
    } geom_t;

    typedef struct packed {
        logic [NUM_W-1:0] add_a;
        logic [NUM_W-1:0] add_b;
        logic [NUM_W-1:0] cmp_a;
        logic [NUM_W-1:0] cmp_b;
    } unit_op_t;

    typedef struct packed {
        logic [NUM_W-1:0] sum;
        logic             less;
    } unit_res_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             pixel_valid;
        status_t          status;
        logic [POS_W-1:0] rows_pending;
        logic             run_last;
        logic             frame_end;
    } result_t;

endpackage

// ----- rtl/core/nnfs_addcmp.sv -----
// Shared 21-bit add and compare unit of the frame scaler.
// Depends on nnfs_pkg.
module nnfs_addcmp (
    input  nnfs_pkg::unit_op_t  op,
    output nnfs_pkg::unit_res_t res
);

    assign res.sum  = op.add_a + op.add_b;
    assign res.less = (op.cmp_a < op.cmp_b);

endmodule

// ----- rtl/core/nnfs_line_store.sv -----
// Single-port-write, registered-read line memory for one source row.
// Depends on nnfs_pkg for the pixel width.
module nnfs_line_store #(
    parameter int LINE_DEPTH = nnfs_pkg::LINE_DEPTH_DEF,
    parameter int AW         = $clog2(LINE_DEPTH)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [nnfs_pkg::PIX_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [nnfs_pkg::PIX_W-1:0] rd_data
);

    logic [nnfs_pkg::PIX_W-1:0] mem [LINE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/nnfs_out_reg.sv -----
// Output register of the frame scaler: holds one result for the master stream.
// Depends on nnfs_pkg for the result type and the stream widths.
module nnfs_out_reg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  nnfs_pkg::result_t            push_res,
    output logic                         can_load,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // out_pixel, out_col, out_row, rows_pending, zero fill
    output logic [nnfs_pkg::TDATA_W-1:0] m_axis_tdata,
    // pixel_valid, status, frame_end
    output logic [nnfs_pkg::TUSER_W-1:0] m_axis_tuser,
    output logic                         m_axis_tlast
);

    logic              valid_reg;
    nnfs_pkg::result_t res_reg;

    assign can_load = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && push)
        begin
            res_reg <= push_res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {7'd0, res_reg.rows_pending, res_reg.row, res_reg.col,
                            res_reg.pixel};
    assign m_axis_tuser  = {res_reg.frame_end, res_reg.status, res_reg.pixel_valid};
    assign m_axis_tlast  = res_reg.run_last;

endmodule

// ----- rtl/core/nnfs_ctrl.sv -----
// Sequencer of the frame scaler: column/row counters, copy loop, owed-row scan.
// Depends on nnfs_pkg; drives nnfs_addcmp, nnfs_line_store and nnfs_out_reg.
module nnfs_ctrl #(
    parameter int LINE_DEPTH = nnfs_pkg::LINE_DEPTH_DEF,
    parameter int MAX_COPIES = nnfs_pkg::MAX_COPIES_DEF,
    parameter int AW         = $clog2(LINE_DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_mode,
    input  logic [nnfs_pkg::PIX_W-1:0] in_pixel,
    input  nnfs_pkg::geom_t            geom,
    output nnfs_pkg::unit_op_t         unit_op,
    input  nnfs_pkg::unit_res_t        unit_res,
    output logic                       mem_wr_en,
    output logic [AW-1:0]              mem_wr_addr,
    output logic                       mem_rd_en,
    output logic [AW-1:0]              mem_rd_addr,
    input  logic [nnfs_pkg::PIX_W-1:0] mem_rd_data,
    output logic                       push,
    output nnfs_pkg::result_t          push_res,
    input  logic                       can_load
);

    localparam int CAP = (MAX_COPIES < nnfs_pkg::RESULT_CAP) ? MAX_COPIES
                                                             : nnfs_pkg::RESULT_CAP;
    localparam int CPW = $clog2(CAP + 1);
    localparam int CW  = ((AW > nnfs_pkg::SRC_W) ? AW : nnfs_pkg::SRC_W) + 1;
    localparam int NW  = nnfs_pkg::NUM_W;

    nnfs_pkg::state_t          state_reg, state_next;
    logic [AW-1:0]             source_col_reg, source_col_next;
    logic [AW-1:0]             replay_col_reg, replay_col_next;
    logic [8:0]                source_row_reg, source_row_next;
    logic [11:0]               output_col_reg, output_col_next;
    logic [11:0]               output_row_reg, output_row_next;
    logic [NW-1:0]             col_num_reg, col_num_next;
    logic [NW-1:0]             col_bound_reg, col_bound_next;
    logic [NW-1:0]             row_num_reg, row_num_next;
    logic [NW-1:0]             row_bound_reg, row_bound_next;
    logic [10:0]               rows_owed_reg, rows_owed_next;
    logic [11:0]               scan_y_reg, scan_y_next;
    logic [NW-1:0]             scan_num_reg, scan_num_next;
    logic [11:0]               scan_cnt_reg, scan_cnt_next;
    logic [CPW-1:0]            copies_reg, copies_next;
    logic                      active_reg, active_next;
    logic                      replay_reg, replay_next;
    logic [nnfs_pkg::PIX_W-1:0] pix_reg, pix_next;
    logic                      hold_v_reg, hold_v_next;
    nnfs_pkg::result_t         hold_reg, hold_next;

    logic                      accept;
    logic                      owed_zero;
    logic                      col_go;
    logic                      src_col_wrap;
    logic                      rep_col_wrap;
    logic                      src_row_wrap;
    logic [nnfs_pkg::PIX_W-1:0] run_pix;
    nnfs_pkg::result_t         empty_res;
    nnfs_pkg::result_t         new_res;

    assign in_ready     = (state_reg == nnfs_pkg::ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign owed_zero    = (rows_owed_reg == 11'd0);
    assign col_go       = unit_res.less && (output_col_reg < geom.dw);
    assign src_col_wrap = (CW'(source_col_reg) + CW'(1)) >= CW'(geom.sw);
    assign rep_col_wrap = (CW'(replay_col_reg) + CW'(1)) >= CW'(geom.sw);
    assign src_row_wrap = (10'(source_row_reg) + 10'd1) >= geom.sh;
    assign run_pix      = replay_reg ? mem_rd_data : pix_reg;

    assign mem_wr_en   = accept && (in_mode == nnfs_pkg::MODE_PIXEL) && owed_zero;
    assign mem_wr_addr = source_col_reg;
    assign mem_rd_en   = accept && (in_mode == nnfs_pkg::MODE_REPLAY) && !owed_zero;
    assign mem_rd_addr = replay_col_reg;

    always_comb
    begin
        empty_res = '0;

        new_res              = '0;
        new_res.pixel        = run_pix;
        new_res.col          = output_col_reg[10:0];
        new_res.row          = output_row_reg[10:0];
        new_res.pixel_valid  = 1'b1;
        new_res.status       = nnfs_pkg::STAT_OK;
        new_res.frame_end    = (output_col_reg == geom.dw - 12'd1)
                            && (output_row_reg == geom.dh - 12'd1);
    end

    always_comb
    begin
        unit_op.add_a = col_num_reg;
        unit_op.add_b = NW'(geom.sw);
        unit_op.cmp_a = col_num_reg;
        unit_op.cmp_b = col_bound_reg;
        case (state_reg)
            nnfs_pkg::ST_IDLE:
            begin
                unit_op.cmp_a = row_num_reg;
                unit_op.cmp_b = row_bound_reg;
            end
            nnfs_pkg::ST_COL_BOUND:
            begin
                unit_op.add_a = col_bound_reg;
                unit_op.add_b = NW'(geom.dw);
            end
            nnfs_pkg::ST_ROW_ADV, nnfs_pkg::ST_REP_END:
            begin
                unit_op.add_a = row_num_reg;
                unit_op.add_b = NW'(geom.sh);
            end
            nnfs_pkg::ST_OWE_SCAN:
            begin
                unit_op.add_a = scan_num_reg;
                unit_op.add_b = NW'(geom.sh);
                unit_op.cmp_a = scan_num_reg;
                unit_op.cmp_b = row_bound_reg;
            end
            nnfs_pkg::ST_ROW_BOUND:
            begin
                unit_op.add_a = row_bound_reg;
                unit_op.add_b = NW'(geom.dh);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        source_col_next = source_col_reg;
        replay_col_next = replay_col_reg;
        source_row_next = source_row_reg;
        output_col_next = output_col_reg;
        output_row_next = output_row_reg;
        col_num_next    = col_num_reg;
        col_bound_next  = col_bound_reg;
        row_num_next    = row_num_reg;
        row_bound_next  = row_bound_reg;
        rows_owed_next  = rows_owed_reg;
        scan_y_next     = scan_y_reg;
        scan_num_next   = scan_num_reg;
        scan_cnt_next   = scan_cnt_reg;
        copies_next     = copies_reg;
        active_next     = active_reg;
        replay_next     = replay_reg;
        pix_next        = pix_reg;
        hold_v_next     = hold_v_reg;
        hold_next       = hold_reg;

        push                  = 1'b0;
        push_res              = hold_reg;
        push_res.rows_pending = rows_owed_reg;
        push_res.run_last     = 1'b0;

        case (state_reg)
            nnfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    copies_next = '0;
                    hold_v_next = 1'b0;
                    if (in_mode == nnfs_pkg::MODE_PIXEL)
                    begin
                        if (!owed_zero)
                        begin
                            hold_next        = empty_res;
                            hold_next.status = nnfs_pkg::STAT_DROPPED;
                            hold_v_next      = 1'b1;
                            state_next       = nnfs_pkg::ST_FINISH;
                        end
                        else
                        begin
                            pix_next    = in_pixel;
                            replay_next = 1'b0;
                            active_next = unit_res.less && (output_row_reg < geom.dh);
                            state_next  = (unit_res.less && (output_row_reg < geom.dh))
                                        ? nnfs_pkg::ST_RUN : nnfs_pkg::ST_SRC_END;
                        end
                    end
                    else
                    begin
                        if (owed_zero)
                        begin
                            hold_next        = empty_res;
                            hold_next.status = nnfs_pkg::STAT_REPLAY_IDLE;
                            hold_v_next      = 1'b1;
                            state_next       = nnfs_pkg::ST_FINISH;
                        end
                        else
                        begin
                            replay_next = 1'b1;
                            state_next  = nnfs_pkg::ST_RUN;
                        end
                    end
                end
            end
            nnfs_pkg::ST_RUN:
            begin
                if (!col_go)
                begin
                    state_next = nnfs_pkg::ST_COL_BOUND;
                end
                else if (copies_reg < CPW'(CAP))
                begin
                    if (!hold_v_reg || can_load)
                    begin
                        push            = hold_v_reg;
                        hold_next       = new_res;
                        hold_v_next     = 1'b1;
                        copies_next     = copies_reg + CPW'(1);
                        output_col_next = output_col_reg + 12'd1;
                        col_num_next    = unit_res.sum;
                    end
                end
                else
                begin
                    output_col_next = output_col_reg + 12'd1;
                    col_num_next    = unit_res.sum;
                end
            end
            nnfs_pkg::ST_COL_BOUND:
            begin
                col_bound_next = unit_res.sum;
                state_next     = replay_reg ? nnfs_pkg::ST_REP_END : nnfs_pkg::ST_SRC_END;
            end
            nnfs_pkg::ST_SRC_END:
            begin
                if (src_col_wrap)
                begin
                    source_col_next = '0;
                    output_col_next = '0;
                    col_num_next    = '0;
                    col_bound_next  = NW'(geom.dw);
                    scan_y_next     = output_row_reg;
                    scan_num_next   = row_num_reg;
                    scan_cnt_next   = '0;
                    state_next      = active_reg ? nnfs_pkg::ST_ROW_ADV
                                                 : nnfs_pkg::ST_OWE_SCAN;
                end
                else
                begin
                    source_col_next = source_col_reg + AW'(1);
                    state_next      = nnfs_pkg::ST_FINISH;
                end
            end
            nnfs_pkg::ST_ROW_ADV:
            begin
                output_row_next = output_row_reg + 12'd1;
                row_num_next    = unit_res.sum;
                scan_y_next     = output_row_reg + 12'd1;
                scan_num_next   = unit_res.sum;
                state_next      = nnfs_pkg::ST_OWE_SCAN;
            end
            nnfs_pkg::ST_OWE_SCAN:
            begin
                if (unit_res.less && (scan_y_reg < geom.dh))
                begin
                    scan_cnt_next = scan_cnt_reg + 12'd1;
                    scan_y_next   = scan_y_reg + 12'd1;
                    scan_num_next = unit_res.sum;
                end
                else
                begin
                    rows_owed_next = scan_cnt_reg[10:0];
                    state_next     = nnfs_pkg::ST_ROW_BOUND;
                end
            end
            nnfs_pkg::ST_ROW_BOUND:
            begin
                row_bound_next  = unit_res.sum;
                replay_col_next = '0;
                if (src_row_wrap)
                begin
                    source_row_next = '0;
                    row_bound_next  = NW'(geom.dh);
                    if (owed_zero)
                    begin
                        output_row_next = '0;
                        row_num_next    = '0;
                    end
                end
                else
                begin
                    source_row_next = source_row_reg + 9'd1;
                end
                state_next = nnfs_pkg::ST_FINISH;
            end
            nnfs_pkg::ST_REP_END:
            begin
                if (rep_col_wrap)
                begin
                    output_col_next = '0;
                    col_num_next    = '0;
                    col_bound_next  = NW'(geom.dw);
                    replay_col_next = '0;
                    output_row_next = output_row_reg + 12'd1;
                    row_num_next    = unit_res.sum;
                    rows_owed_next  = rows_owed_reg - 11'd1;
                    if ((rows_owed_reg == 11'd1) && (source_row_reg == 9'd0))
                    begin
                        output_row_next = '0;
                        row_num_next    = '0;
                        row_bound_next  = NW'(geom.dh);
                    end
                end
                else
                begin
                    replay_col_next = replay_col_reg + AW'(1);
                end
                state_next = nnfs_pkg::ST_FINISH;
            end
            nnfs_pkg::ST_FINISH:
            begin
                if (can_load)
                begin
                    push = 1'b1;
                    if (!hold_v_reg)
                    begin
                        push_res              = empty_res;
                        push_res.rows_pending = rows_owed_reg;
                    end
                    push_res.run_last = 1'b1;
                    hold_v_next       = 1'b0;
                    state_next        = nnfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nnfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nnfs_pkg::ST_IDLE;
            source_col_reg <= '0;
            replay_col_reg <= '0;
            source_row_reg <= '0;
            output_col_reg <= '0;
            output_row_reg <= '0;
            col_num_reg    <= '0;
            col_bound_reg  <= NW'(nnfs_pkg::DST_WIDTH_RST);
            row_num_reg    <= '0;
            row_bound_reg  <= NW'(nnfs_pkg::DST_HEIGHT_RST);
            rows_owed_reg  <= '0;
            scan_y_reg     <= '0;
            scan_num_reg   <= '0;
            scan_cnt_reg   <= '0;
            copies_reg     <= '0;
            active_reg     <= 1'b0;
            replay_reg     <= 1'b0;
            hold_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            source_col_reg <= source_col_next;
            replay_col_reg <= replay_col_next;
            source_row_reg <= source_row_next;
            output_col_reg <= output_col_next;
            output_row_reg <= output_row_next;
            col_num_reg    <= col_num_next;
            col_bound_reg  <= col_bound_next;
            row_num_reg    <= row_num_next;
            row_bound_reg  <= row_bound_next;
            rows_owed_reg  <= rows_owed_next;
            scan_y_reg     <= scan_y_next;
            scan_num_reg   <= scan_num_next;
            scan_cnt_reg   <= scan_cnt_next;
            copies_reg     <= copies_next;
            active_reg     <= active_next;
            replay_reg     <= replay_next;
            hold_v_reg     <= hold_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg  <= pix_next;
        hold_reg <= hold_next;
    end

endmodule

// ----- rtl/core/nearest_neighbour_frame_scaler_core.sv -----
// Nearest-neighbor frame scaler, top level: config registers, geometry clamp, assertions.
// Depends on nnfs_pkg, nnfs_addcmp, nnfs_line_store, nnfs_out_reg and nnfs_ctrl.
//
// Source pixels (tuser 0) enter in raster order and come out as up to four copies
// on the current output row; replay requests (tuser 1) re-send one stored column for
// each repeated output row. Work runs through one sequencer around a shared 21-bit
// add/compare unit that steps one output column or one output row per cycle, the
// column steps stalling on backpressure as noted below. The pixel that closes a
// source row also scans the repeated rows it leaves owed, and a status-only request
// yields only its closing result. Register writes are taken only while the core is
// idle and no request is offered. The output register holds the last result while
// the next request starts; backpressure stalls the column loop only when a second
// copy waits.
module nearest_neighbour_frame_scaler_core #(
    parameter int LINE_DEPTH = nnfs_pkg::LINE_DEPTH_DEF,
    parameter int MAX_COPIES = nnfs_pkg::MAX_COPIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // in_pixel
    input  logic [nnfs_pkg::PIX_W-1:0]   s_axis_tdata,
    // mode
    input  logic [0:0]                   s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // out_pixel, out_col, out_row, rows_pending, zero fill
    output logic [nnfs_pkg::TDATA_W-1:0] m_axis_tdata,
    // pixel_valid, status, frame_end
    output logic [nnfs_pkg::TUSER_W-1:0] m_axis_tuser,
    output logic                         m_axis_tlast,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [nnfs_pkg::CFG_W-1:0]   cfg_data
);

    localparam int AW     = $clog2(LINE_DEPTH);
    localparam int SW_CAP = (LINE_DEPTH < 1023) ? LINE_DEPTH : 1023;

    logic [nnfs_pkg::SRC_W-1:0] src_width_reg;
    logic [nnfs_pkg::SRC_W-1:0] src_height_reg;
    logic [nnfs_pkg::DST_W-1:0] dst_width_reg;
    logic [nnfs_pkg::DST_W-1:0] dst_height_reg;

    nnfs_pkg::geom_t     geom;
    nnfs_pkg::unit_op_t  unit_op;
    nnfs_pkg::unit_res_t unit_res;
    nnfs_pkg::result_t   push_res;
    logic                push;
    logic                can_load;
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    logic [nnfs_pkg::PIX_W-1:0] mem_rd_data;

    // writes only between requests
    assign cfg_ready = s_axis_tready && !s_axis_tvalid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= nnfs_pkg::SRC_W'(nnfs_pkg::SRC_WIDTH_RST);
            src_height_reg <= nnfs_pkg::SRC_W'(nnfs_pkg::SRC_HEIGHT_RST);
            dst_width_reg  <= nnfs_pkg::DST_W'(nnfs_pkg::DST_WIDTH_RST);
            dst_height_reg <= nnfs_pkg::DST_W'(nnfs_pkg::DST_HEIGHT_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (nnfs_pkg::cfg_idx_t'(cfg_index))
                nnfs_pkg::CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[nnfs_pkg::SRC_W-1:0];
                nnfs_pkg::CFG_SRC_HEIGHT: src_height_reg <= cfg_data[nnfs_pkg::SRC_W-1:0];
                nnfs_pkg::CFG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                nnfs_pkg::CFG_DST_HEIGHT: dst_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // zero acts as one, oversize saturates
    always_comb
    begin
        geom.sw = (src_width_reg == '0) ? nnfs_pkg::SRC_W'(1)
                : (src_width_reg > nnfs_pkg::SRC_W'(SW_CAP)) ? nnfs_pkg::SRC_W'(SW_CAP)
                : src_width_reg;
        geom.sh = (src_height_reg == '0) ? nnfs_pkg::SRC_W'(1)
                : (src_height_reg > nnfs_pkg::SRC_W'(nnfs_pkg::SRC_H_MAX))
                ? nnfs_pkg::SRC_W'(nnfs_pkg::SRC_H_MAX) : src_height_reg;
        geom.dw = (dst_width_reg == '0) ? nnfs_pkg::DST_W'(1)
                : (dst_width_reg > nnfs_pkg::DST_W'(nnfs_pkg::DST_MAX))
                ? nnfs_pkg::DST_W'(nnfs_pkg::DST_MAX) : dst_width_reg;
        geom.dh = (dst_height_reg == '0) ? nnfs_pkg::DST_W'(1)
                : (dst_height_reg > nnfs_pkg::DST_W'(nnfs_pkg::DST_MAX))
                ? nnfs_pkg::DST_W'(nnfs_pkg::DST_MAX) : dst_height_reg;
    end

    nnfs_addcmp u_addcmp (
        .op  (unit_op),
        .res (unit_res)
    );

    nnfs_line_store #(
        .LINE_DEPTH (LINE_DEPTH),
        .AW         (AW)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (s_axis_tdata),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    nnfs_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .push_res      (push_res),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    nnfs_ctrl #(
        .LINE_DEPTH (LINE_DEPTH),
        .MAX_COPIES (MAX_COPIES),
        .AW         (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_mode     (s_axis_tuser[0]),
        .in_pixel    (s_axis_tdata),
        .geom        (geom),
        .unit_op     (unit_op),
        .unit_res    (unit_res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .push        (push),
        .push_res    (push_res),
        .can_load    (can_load)
    );

    // one request in flight at a time
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while a request was in flight");

    // only pixel copies precede the closing result of a request
    a_mid_run_has_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser[0])
        else $error("non-final result without pixel");

    // a pixel is dropped only while repeated rows are owed
    a_drop_needs_owed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:1] == nnfs_pkg::STAT_DROPPED))
        |-> (m_axis_tdata[48:38] != 11'd0))
        else $error("dropped pixel with no rows owed");

endmodule
